[sv/pcw_pkg.sv]
// Shared types and constants for the PCI capability walker.
package pcw_pkg;

  // Configuration space geometry: 64 dwords of four bytes.
  localparam int CFG_DWORDS = 64;
  localparam int CFG_AW     = $clog2(CFG_DWORDS);

  // Longest capability chain followed before a search gives up.
  localparam int MAX_HOPS = 48;
  localparam int HOP_W    = $clog2(MAX_HOPS + 1);

  // Dwords and bit positions of the header fields used by the walk.
  localparam logic [CFG_AW-1:0] DW_STATUS   = CFG_AW'(1);   // status at byte 0x06
  localparam logic [CFG_AW-1:0] DW_HDR_TYPE = CFG_AW'(3);   // header type at byte 0x0E
  localparam int                STATUS_CAP_BIT = 20;        // status bit 4, byte 2
  localparam int                PMC_D1_BIT     = 25;        // PMC bit 9, byte 3
  localparam int                PMC_D2_BIT     = 26;        // PMC bit 10, byte 3

  // Pointer and ID constants of the capability list.
  localparam logic [7:0] CAP_PTR_STD = 8'h34;
  localparam logic [7:0] CAP_PTR_CB  = 8'h14;
  localparam logic [7:0] CAP_MIN     = 8'h40;
  localparam logic [7:0] CAP_ID_END  = 8'hFF;
  localparam logic [6:0] HDR_MASK    = 7'h7F;
  localparam logic [6:0] HDR_CARDBUS = 7'd2;
  localparam logic [1:0] PM_STATE_D1 = 2'd1;
  localparam logic [1:0] PM_STATE_D2 = 2'd2;

  // Stream widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FIND  = 2'd1,
    KIND_GET   = 2'd2,
    KIND_SET   = 2'd3
  } pcw_kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAT,
    ST_HDR,
    ST_PTR,
    ST_ID,
    ST_PMCSR,
    ST_DONE
  } pcw_state_t;

  // One access to the configuration store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [CFG_AW-1:0] addr;
    logic [3:0]        be;
    logic [31:0]       wdata;
  } pcw_ram_req_t;

endpackage

[sv/pcw_cfg_ram.sv]
// Configuration space store: 64 byte-enabled dwords with registered read.
module pcw_cfg_ram (
  input  logic                 clk,
  input  logic                 rst,
  input  pcw_pkg::pcw_ram_req_t req,
  output logic [31:0]          rdata
);
  import pcw_pkg::*;

  logic [3:0][7:0]     mem [CFG_DWORDS];
  logic [CFG_DWORDS-1:0] valid;
  logic [3:0][7:0]     rdata_q;
  logic                rvalid_q;
  logic [3:0][7:0]     wbytes;
  logic [3:0]          wmask;

  // A dword never written reads as zero, so its first write fills the
  // disabled bytes with zeros.
  assign wbytes = req.wdata;
  assign wmask  = valid[req.addr] ? req.be : 4'hF;

  // Byte lane writes.
  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (req.we && wmask[b]) begin
        mem[req.addr][b] <= req.be[b] ? wbytes[b] : 8'h00;
      end
    end
  end

  // Written flags, cleared together at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.addr] <= 1'b1;
    end
  end

  // Registered read with the written flag carried alongside.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_q  <= mem[req.addr];
      rvalid_q <= valid[req.addr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : 32'h0;

endmodule

[sv/pcw_walker.sv]
// Item sequencer: writes, capability list walk and power state access.
module pcw_walker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [5:0]            dword_index,
  input  logic [3:0]            byte_enables,
  input  logic [31:0]           write_data,
  input  logic [7:0]            cap_id,
  input  logic [1:0]            requested_state,
  input  logic [7:0]            pm_id,
  output pcw_pkg::pcw_ram_req_t ram_req,
  input  logic [31:0]           rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  status,
  output logic [7:0]            cap_offset,
  output logic [1:0]            current_state
);
  import pcw_pkg::*;

  pcw_state_t state, state_next;
  pcw_kind_t  kind_q;
  logic [1:0] req_q;
  logic [7:0] id_q;
  logic [7:0] ptr;
  logic [7:0] cap;
  logic [HOP_W-1:0] hop;
  logic       pmc_d1, pmc_d2;
  logic       res_status;
  logic [7:0] res_off;
  logic [1:0] res_cur;

  logic [3:0][7:0] rd_bytes;
  logic [7:0] nxt;
  logic [6:0] hdr;
  logic [7:0] hdr_ptr;
  logic [7:0] pm_addr;
  logic [7:0] ptr_after;
  logic       stat_ok, hdr_ok, ptr_bad, id_end, id_hit, last_hop, set_ok;
  logic       fail, out_free;

  // Decode of the byte just read.
  assign rd_bytes  = rdata;
  assign nxt       = rd_bytes[ptr[1:0]];
  assign hdr       = rd_bytes[2][6:0] & HDR_MASK;
  assign hdr_ptr   = (hdr == HDR_CARDBUS) ? CAP_PTR_CB : CAP_PTR_STD;
  assign pm_addr   = cap + 8'd4;
  assign ptr_after = cap + 8'd1;
  assign stat_ok   = rdata[STATUS_CAP_BIT];
  assign hdr_ok    = (hdr <= HDR_CARDBUS);
  assign ptr_bad   = (nxt < CAP_MIN) || (nxt[1:0] != 2'b00);
  assign id_end    = (rd_bytes[0] == CAP_ID_END);
  assign id_hit    = !id_end && (rd_bytes[0] == id_q);
  assign last_hop  = (hop == HOP_W'(MAX_HOPS - 1));
  assign set_ok    = !((req_q == PM_STATE_D1) && !pmc_d1) &&
                     !((req_q == PM_STATE_D2) && !pmc_d2);
  assign out_free  = !out_valid || out_ready;

  // Conditions that end a search without a capability.
  always_comb begin
    unique case (state)
      ST_STAT: fail = !stat_ok;
      ST_HDR:  fail = !hdr_ok;
      ST_PTR:  fail = ptr_bad;
      ST_ID:   fail = id_end || (!id_hit && last_hop);
      default: fail = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (pcw_kind_t'(kind) == KIND_WRITE) ? ST_DONE : ST_STAT;
        end
      end
      ST_STAT: state_next = fail ? ST_DONE : ST_HDR;
      ST_HDR:  state_next = fail ? ST_DONE : ST_PTR;
      ST_PTR:  state_next = fail ? ST_DONE : ST_ID;
      ST_ID: begin
        if (fail) begin
          state_next = ST_DONE;
        end else if (id_hit) begin
          state_next = (kind_q == KIND_FIND) ? ST_DONE : ST_PMCSR;
        end else begin
          state_next = ST_PTR;
        end
      end
      ST_PMCSR: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store accesses; a write and a read never share a cycle.
  always_comb begin
    ram_req = '0;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid && pcw_kind_t'(kind) == KIND_WRITE) begin
          ram_req.we    = 1'b1;
          ram_req.addr  = dword_index;
          ram_req.be    = byte_enables;
          ram_req.wdata = write_data;
        end else if (in_valid) begin
          ram_req.re   = 1'b1;
          ram_req.addr = DW_STATUS;
        end
      end
      ST_STAT: begin
        ram_req.re   = !fail;
        ram_req.addr = DW_HDR_TYPE;
      end
      ST_HDR: begin
        ram_req.re   = !fail;
        ram_req.addr = hdr_ptr[7:2];
      end
      ST_PTR: begin
        ram_req.re   = !fail;
        ram_req.addr = nxt[7:2];
      end
      ST_ID: begin
        ram_req.re   = !fail && (!id_hit || kind_q != KIND_FIND);
        ram_req.addr = id_hit ? pm_addr[7:2] : ptr_after[7:2];
      end
      ST_PMCSR: begin
        ram_req.we    = (kind_q == KIND_SET) && set_ok;
        ram_req.addr  = pm_addr[7:2];
        ram_req.be    = 4'b0001;
        ram_req.wdata = {24'h0, rd_bytes[0][7:2], req_q};
      end
      default: ;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk registers and the pending result.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      kind_q     <= pcw_kind_t'(kind);
      req_q      <= requested_state;
      id_q       <= (pcw_kind_t'(kind) == KIND_FIND) ? cap_id : pm_id;
      hop        <= '0;
      res_status <= 1'b0;
      res_off    <= 8'h00;
      res_cur    <= 2'd0;
    end else begin
      if (fail) begin
        res_status <= 1'b1;
      end
      if (state == ST_HDR) begin
        ptr <= hdr_ptr;
      end
      if (state == ST_PTR) begin
        cap <= nxt;
      end
      if (state == ST_ID) begin
        pmc_d1 <= rdata[PMC_D1_BIT];
        pmc_d2 <= rdata[PMC_D2_BIT];
        if (id_hit) begin
          res_off <= cap;
        end else begin
          ptr <= ptr_after;
          hop <= hop + HOP_W'(1);
        end
      end
      if (state == ST_PMCSR) begin
        res_cur    <= rd_bytes[0][1:0];
        res_status <= (kind_q == KIND_SET) && !set_ok;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status        <= res_status;
      cap_offset    <= res_off;
      current_state <= res_cur;
    end
  end

endmodule

[sv/pci_capability_walker.sv]
// Top level: stream ports, power capability ID register, store and sequencer.
// One item is in work at a time. A find makes one store read per header field
// and two per hop (pointer, then ID); get and set add one read of the PMCSR.
// Reset clears the written flag of every dword, so the whole space reads as
// zero at once with no clearing pass, and sets the power capability ID to 1.
module pci_capability_walker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // dword_index, byte_enables, write_data, cap_id, requested_state, zero fill
  input  logic [pcw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // kind
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, cap_offset, current_state, zero fill
  output logic [pcw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import pcw_pkg::*;

  logic [7:0]   pm_id;
  pcw_ram_req_t ram_req;
  logic [31:0]  rdata;
  logic         res_status;
  logic [7:0]   res_off;
  logic [1:0]   res_cur;

  // Power management capability ID register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pm_id <= 8'd1;
    end else if (cfg_we) begin
      pm_id <= cfg_wdata;
    end
  end

  pcw_cfg_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (rdata)
  );

  pcw_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .kind            (s_axis_tuser),
    .dword_index     (s_axis_tdata[5:0]),
    .byte_enables    (s_axis_tdata[9:6]),
    .write_data      (s_axis_tdata[41:10]),
    .cap_id          (s_axis_tdata[49:42]),
    .requested_state (s_axis_tdata[51:50]),
    .pm_id           (pm_id),
    .ram_req         (ram_req),
    .rdata           (rdata),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .status          (res_status),
    .cap_offset      (res_off),
    .current_state   (res_cur)
  );

  // Result packing.
  assign m_axis_tdata = {5'd0, res_cur, res_off, res_status};

  // One item at a time: no acceptance right after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in work");

  // A reported capability offset lies in the capability area and is aligned.
  a_off_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_off != 8'h00 |-> res_off >= CAP_MIN && res_off[1:0] == 2'b00)
    else $error("capability offset outside the list area");

  // A result without a capability offset carries no power state.
  a_miss_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_off == 8'h00 |-> res_cur == 2'd0)
    else $error("power state reported without a capability");

  // The store never sees a read and a write in the same cycle.
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> !ram_req.re)
    else $error("store read and write collide");

endmodule

[tb/tb_pci_capability_walker.sv]
// Testbench for the PCI capability walker: random capability lists checked against a predictor.
module tb_pci_capability_walker;
  import pcw_pkg::*;

  // Byte addresses and bit positions that the capability search relies on.
  localparam logic [7:0] STATUS_BYTE    = 8'h06;
  localparam logic [7:0] HDR_BYTE       = 8'h0E;
  localparam int         CAP_LIST_BIT   = 4;
  localparam logic [7:0] PMC_OFS        = 8'd2;
  localparam logic [7:0] PMCSR_OFS      = 8'd4;
  localparam int         PMC_D1_SUPPORT = 9;
  localparam int         PMC_D2_SUPPORT = 10;
  localparam logic [1:0] PM_STATE_D0    = 2'd0;
  localparam logic [1:0] PM_STATE_D3    = 2'd3;
  localparam int         CYCLE_LIMIT    = 1000000;

  typedef struct packed {
    pcw_kind_t   kind;
    logic [5:0]  idx;
    logic [3:0]  be;
    logic [31:0] data;
    logic [7:0]  cap;
    logic [1:0]  req;
  } walk_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] offset;
    logic [1:0] state;
  } walk_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [7:0]             cfg_wdata = 8'd0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = 2'd0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state: the configuration space image and the power capability ID.
  logic [31:0]  space_image [CFG_DWORDS];
  logic [7:0]   pm_id_model;
  walk_result_t pending_results [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int items_sent = 0;
  int failures = 0;
  int cycles = 0;

  pci_capability_walker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_pci_capability_walker NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Byte access to the predicted configuration space; addresses wrap at 256.
  function automatic logic [7:0] space_byte(logic [7:0] a);
    return space_image[a[7:2]][8*a[1:0] +: 8];
  endfunction

  function automatic void space_byte_write(logic [7:0] a, logic [7:0] v);
    space_image[a[7:2]][8*a[1:0] +: 8] = v;
  endfunction

  // Walk the capability list for an ID; returns its offset or 0 when absent.
  function automatic logic [7:0] locate_cap(logic [7:0] id);
    logic [7:0] stat;
    logic [7:0] ptr;
    logic [7:0] nxt;
    logic [6:0] hdr;
    stat = space_byte(STATUS_BYTE);
    if (!stat[CAP_LIST_BIT]) return 8'd0;
    hdr = 7'(space_byte(HDR_BYTE)) & HDR_MASK;
    if (hdr == 7'd0 || hdr == 7'd1) ptr = CAP_PTR_STD;
    else if (hdr == HDR_CARDBUS) ptr = CAP_PTR_CB;
    else return 8'd0;
    for (int hop = 0; hop < MAX_HOPS; hop++) begin
      nxt = space_byte(ptr);
      if (nxt < CAP_MIN || nxt[1:0] != 2'd0) return 8'd0;
      if (space_byte(nxt) == CAP_ID_END) return 8'd0;
      if (space_byte(nxt) == id) return nxt;
      ptr = nxt + 8'd1;
    end
    return 8'd0;
  endfunction

  // Work out the result of one item and apply its effect on the space image.
  function automatic walk_result_t predict_item(walk_item_t it);
    walk_result_t r;
    logic [7:0]   off;
    logic [7:0]   csr;
    logic [15:0]  pmc;
    r = '0;
    case (it.kind)
      KIND_WRITE: begin
        for (int b = 0; b < 4; b++)
          if (it.be[b]) space_image[it.idx][8*b +: 8] = it.data[8*b +: 8];
      end
      KIND_FIND: begin
        off = locate_cap(it.cap);
        r.status = (off == 8'd0);
        r.offset = off;
      end
      default: begin
        off = locate_cap(pm_id_model);
        if (off == 8'd0) begin
          r.status = 1'b1;
        end else begin
          r.offset = off;
          csr = space_byte(off + PMCSR_OFS);
          r.state = csr[1:0];
          if (it.kind == KIND_SET) begin
            pmc = {space_byte(off + PMC_OFS + 8'd1), space_byte(off + PMC_OFS)};
            if ((it.req == PM_STATE_D1 && !pmc[PMC_D1_SUPPORT]) ||
                (it.req == PM_STATE_D2 && !pmc[PMC_D2_SUPPORT]))
              r.status = 1'b1;
            else
              space_byte_write(off + PMCSR_OFS, {csr[7:2], it.req});
          end
        end
      end
    endcase
    return r;
  endfunction

  // Result checker: each item leaving the block is matched to the oldest prediction.
  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[0];
      got.offset = m_axis_tdata[8:1];
      got.state  = m_axis_tdata[10:9];
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: tdata %h", m_axis_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
        if (got.offset !== want.offset) begin
          $error("cap_offset: expected %h, got %h", want.offset, got.offset);
          failures++;
        end
        if (got.state !== want.state) begin
          $error("current_state: expected %0d, got %0d", want.state, got.state);
          failures++;
        end
      end
    end
  end

  function automatic walk_item_t make_item(pcw_kind_t k, logic [5:0] idx, logic [3:0] be,
                                           logic [31:0] data, logic [7:0] cap,
                                           logic [1:0] req);
    walk_item_t it;
    it.kind = k;
    it.idx  = idx;
    it.be   = be;
    it.data = data;
    it.cap  = cap;
    it.req  = req;
    return it;
  endfunction

  // An item of the given kind with every field random.
  function automatic walk_item_t random_item(pcw_kind_t k);
    return make_item(k, 6'($urandom), 4'($urandom), $urandom, 8'($urandom), 2'($urandom));
  endfunction

  // Send one item; called and returns at a falling edge.
  task automatic send_item(walk_item_t it);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {4'd0, it.req, it.cap, it.data, it.be, it.idx};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_item(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Write the power capability ID while the block is idle.
  task automatic write_pm_id(logic [7:0] v);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    pm_id_model = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idle(int snd, int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // Lay out a random capability list, then query it with finds, gets and sets.
  task automatic build_cap_list();
    walk_item_t it;
    int         slots [24];
    logic [7:0] offs [24];
    logic [7:0] ids [24];
    logic [7:0] nxt;
    logic [6:0] hdr;
    int         n;
    int         pm_pos;
    int         term;
    int         pick;
    int         j;
    int         tmp;
    int         queries;
    for (int i = 0; i < 24; i++) slots[i] = 16 + 2*i;
    for (int i = 23; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    pm_pos = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      offs[i] = 8'(slots[i] * 4);
      ids[i]  = 8'($urandom_range(0, 254));
      if (i == pm_pos && $urandom_range(0, 4) != 0) ids[i] = pm_id_model;
    end
    term = $urandom_range(0, 9);
    pick = $urandom_range(0, 9);
    hdr = (pick < 4) ? 7'd0 : (pick < 7) ? 7'd1 : (pick < 9) ? HDR_CARDBUS :
          7'($urandom_range(3, 127));

    // Header: capability list flag, header type and the start pointer.
    it = random_item(KIND_WRITE);
    it.idx = DW_STATUS;
    it.be[2] = 1'b1;
    it.data[STATUS_CAP_BIT] = ($urandom_range(0, 9) != 0);
    send_item(it);
    it = random_item(KIND_WRITE);
    it.idx = DW_HDR_TYPE;
    it.be[2] = 1'b1;
    it.data[22:16] = hdr;
    send_item(it);
    it = random_item(KIND_WRITE);
    it.idx = (hdr == HDR_CARDBUS) ? CAP_PTR_CB[7:2] : CAP_PTR_STD[7:2];
    it.be[0] = 1'b1;
    it.data[7:0] = offs[0];
    send_item(it);

    // Capability entries; the last one ends the list in one of several ways.
    for (int i = 0; i < n; i++) begin
      nxt = (i < n - 1) ? offs[i + 1] : 8'd0;
      if (i == n - 1) begin
        case (term)
          6:       nxt = 8'($urandom_range(0, 63));
          7:       nxt = {6'($urandom_range(16, 63)), 2'($urandom_range(1, 3))};
          8:       nxt = offs[$urandom_range(0, i)];
          9:       ids[i] = CAP_ID_END;
          default: nxt = 8'd0;
        endcase
      end
      it = random_item(KIND_WRITE);
      it.idx = 6'(slots[i]);
      it.be = ($urandom_range(0, 5) == 0) ? 4'b0011 : 4'b1111;
      it.data[7:0]  = ids[i];
      it.data[15:8] = nxt;
      send_item(it);
      if (i == pm_pos || $urandom_range(0, 1) == 0) begin
        it = random_item(KIND_WRITE);
        it.idx = 6'(slots[i] + 1);
        it.be[0] = 1'b1;
        send_item(it);
      end
    end

    // Queries against the list, with a little write noise.
    queries = $urandom_range(8, 20);
    for (int q = 0; q < queries; q++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        it = random_item(KIND_FIND);
        if ($urandom_range(0, 9) < 7) it.cap = ids[$urandom_range(0, n - 1)];
      end else if (pick < 13) begin
        it = random_item(KIND_GET);
      end else if (pick < 19) begin
        it = random_item(KIND_SET);
      end else begin
        it = random_item(KIND_WRITE);
      end
      send_item(it);
    end
    if ($urandom_range(0, 9) == 0) wait_all_results();
  endtask

  // Hand-built lists covering each stop condition, the power requests and wrap-around.
  task automatic test_directed();
    // Empty space: no capability list at all.
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h01, 2'd0));
    send_item(make_item(KIND_GET, 6'd63, 4'hF, 32'hFFFF_FFFF, 8'hFF, PM_STATE_D3));
    send_item(make_item(KIND_SET, 6'd0, 4'd0, 32'd0, 8'd0, PM_STATE_D3));
    // List at 0x40 (power capability) then 0x48 with a misaligned next pointer.
    send_item(make_item(KIND_WRITE, DW_STATUS, 4'b0100, 32'h0010_0000, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, CAP_PTR_STD[7:2], 4'b0001, 32'h0000_0040, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, 6'd16, 4'hF, 32'h0600_4801, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, 6'd17, 4'b0001, 32'h0000_00FF, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, 6'd18, 4'hF, 32'hFFFF_4D10, 8'd0, 2'd0));
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h10, 2'd0));
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h01, 2'd0));
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h22, 2'd0));
    send_item(make_item(KIND_GET, 6'd0, 4'd0, 32'd0, 8'd0, 2'd0));
    send_item(make_item(KIND_SET, 6'd0, 4'd0, 32'd0, 8'd0, PM_STATE_D1));
    // Clear D1 and D2 support: D2 is refused, D0 is always allowed.
    send_item(make_item(KIND_WRITE, 6'd16, 4'b1000, 32'd0, 8'd0, 2'd0));
    send_item(make_item(KIND_SET, 6'd0, 4'd0, 32'd0, 8'd0, PM_STATE_D2));
    send_item(make_item(KIND_SET, 6'd0, 4'd0, 32'd0, 8'd0, PM_STATE_D0));
    // Entry at 0x48 points to itself: the search runs out of hops.
    send_item(make_item(KIND_WRITE, 6'd18, 4'b0010, 32'h0000_4800, 8'd0, 2'd0));
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h22, 2'd0));
    // CardBus header: list starts at 0x14, capability at 0xFC, PMCSR wraps to 0x00.
    send_item(make_item(KIND_WRITE, DW_HDR_TYPE, 4'b0100, 32'h0082_0000, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, CAP_PTR_CB[7:2], 4'b0001, 32'h0000_00FC, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, 6'd63, 4'hF, 32'h0200_0001, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, 6'd0, 4'b0001, 32'h0000_0002, 8'd0, 2'd0));
    send_item(make_item(KIND_GET, 6'd0, 4'd0, 32'd0, 8'd0, 2'd0));
    send_item(make_item(KIND_SET, 6'd0, 4'd0, 32'd0, 8'd0, PM_STATE_D1));
    // Unknown header type stops the search.
    send_item(make_item(KIND_WRITE, DW_HDR_TYPE, 4'b0100, 32'h0005_0000, 8'd0, 2'd0));
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h01, 2'd0));
    // Header type 1 and an end-of-list ID at 0x40.
    send_item(make_item(KIND_WRITE, DW_HDR_TYPE, 4'b0100, 32'h0001_0000, 8'd0, 2'd0));
    send_item(make_item(KIND_WRITE, 6'd16, 4'b0001, 32'h0000_00FF, 8'd0, 2'd0));
    send_item(make_item(KIND_FIND, 6'd0, 4'd0, 32'd0, 8'h10, 2'd0));
    wait_all_results();
  endtask

  // Power requests with the capability ID at both ends of its range.
  task automatic test_pm_id_extremes();
    write_pm_id(8'h00);
    repeat (3) build_cap_list();
    wait_all_results();
    write_pm_id(8'hFF);
    repeat (2) build_cap_list();
    wait_all_results();
  endtask

  // Random lists under one power capability ID, until about count items have gone.
  task automatic test_random_lists(int count);
    int first;
    wait_all_results();
    write_pm_id(($urandom_range(0, 3) == 0) ? 8'h01 : 8'($urandom_range(0, 254)));
    first = items_sent;
    while (items_sent - first < count) build_cap_list();
    wait_all_results();
  endtask

  initial begin
    for (int i = 0; i < CFG_DWORDS; i++) space_image[i] = 32'd0;
    pm_id_model = 8'h01;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idle(22, 64);
    test_directed();
    test_pm_id_extremes();
    test_random_lists(450);
    set_idle(64, 22);
    test_random_lists(450);
    set_idle(0, 0);
    test_random_lists(450);

    wait_all_results();
    repeat (120) @(posedge clk);
    if (failures == 0)
      $display("tb_pci_capability_walker OK");
    else
      $display("tb_pci_capability_walker NOT OK");
    $finish;
  end

endmodule

[sim.f]
sv/pcw_pkg.sv
sv/pcw_cfg_ram.sv
sv/pcw_walker.sv
sv/pci_capability_walker.sv
tb/tb_pci_capability_walker.sv
